### hdl/array_list_push_remove_by_value_assert.svh
// Assertion macros shared by the list block.
`ifndef ARRAY_LIST_PUSH_REMOVE_BY_VALUE_ASSERT_SVH
`define ARRAY_LIST_PUSH_REMOVE_BY_VALUE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define ALPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define ALPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/alpr_pkg.sv
// Types, sizes and helpers for the push / remove-by-value list.
package alpr_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned POS_W   = 4;

  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  typedef enum logic {
    CMD_PUSH   = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_TAIL_RD,
    ST_TAIL_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [WORD_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    status_e                  status;
    logic [COUNT_W-1:0]       count;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] tail_value;
  } out_beat_t;

  function automatic logic [CNT_W-1:0] widen_idx(input logic [IDX_W-1:0] idx);
    return CNT_W'(idx);
  endfunction

  function automatic logic [IDX_W-1:0] cnt_to_idx(input logic [CNT_W-1:0] cnt);
    return IDX_W'(cnt);
  endfunction

  function automatic logic [COUNT_W-1:0] cnt_to_count(input logic [CNT_W-1:0] cnt);
    return COUNT_W'(cnt);
  endfunction

  function automatic logic [POS_W-1:0] idx_to_pos(input logic [IDX_W-1:0] idx);
    return POS_W'(idx);
  endfunction

endpackage

### hdl/alpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module alpr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/array_list_push_remove_by_value.sv
// Top level: ordered word list with push at tail and remove of first match.
//
// A push is written to the entry RAM in the cycle it is accepted and moves to
// ST_DONE, which loads its result into the output register once that register
// is free. A remove walks the list through the single read port of the
// entry RAM, one entry per cycle: it reads each entry up to and including the
// match to find the value, then moves each later entry down one place to close
// the gap, so the two passes together never cover more than DEPTH entries.
// ST_TAIL_RD and ST_TAIL_WAIT then fetch the new tail and ST_DONE loads the
// result. Full, empty and not-found results change nothing. The block
// takes one command at a time; in_ready_o is high while the sequencer is
// idle, and a finished result waits in the output register without blocking
// the next command. There is no clearing pass after reset.
`include "array_list_push_remove_by_value_assert.svh"

module array_list_push_remove_by_value (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  alpr_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output alpr_pkg::out_beat_t out_data_o
);

  alpr_pkg::state_e state_q, state_d;

  logic [alpr_pkg::CNT_W-1:0]         fill_q, fill_d;
  logic signed [alpr_pkg::WORD_W-1:0] tail_q, tail_d;
  logic signed [alpr_pkg::WORD_W-1:0] value_q, value_d;
  alpr_pkg::status_e                  status_q, status_d;
  logic [alpr_pkg::IDX_W-1:0]         pos_q, pos_d;
  logic [alpr_pkg::IDX_W-1:0]         scan_q, scan_d;
  logic [alpr_pkg::IDX_W-1:0]         ptr_q, ptr_d;
  logic                               out_valid_q, out_valid_d;
  alpr_pkg::out_beat_t                out_data_q, out_data_d;

  logic                        ram_we;
  logic [alpr_pkg::IDX_W-1:0]  ram_waddr;
  logic [alpr_pkg::WORD_W-1:0] ram_wdata;
  logic [alpr_pkg::IDX_W-1:0]  ram_raddr;
  logic [alpr_pkg::WORD_W-1:0] ram_rdata;

  logic                       accept;
  logic                       is_push;
  logic                       full;
  logic                       empty;
  logic                       match;
  logic                       out_free;
  logic [alpr_pkg::CNT_W-1:0] fill_inc;
  logic [alpr_pkg::CNT_W-1:0] fill_dec;
  logic [alpr_pkg::CNT_W-1:0] scan_next;
  logic [alpr_pkg::CNT_W-1:0] ptr_inc;
  logic [alpr_pkg::CNT_W-1:0] ptr_next2;

  assign in_ready_o = (state_q == alpr_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_push    = (in_data_i.cmd == alpr_pkg::CMD_PUSH);
  assign full       = (fill_q == alpr_pkg::FULL_CNT);
  assign empty      = (fill_q == '0);
  assign match      = (ram_rdata == value_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign fill_inc   = fill_q + alpr_pkg::CNT_ONE;
  assign fill_dec   = fill_q - alpr_pkg::CNT_ONE;
  assign scan_next  = alpr_pkg::widen_idx(scan_q) + alpr_pkg::CNT_ONE;
  assign ptr_inc    = alpr_pkg::widen_idx(ptr_q) + alpr_pkg::CNT_ONE;
  assign ptr_next2  = alpr_pkg::widen_idx(ptr_q) + alpr_pkg::CNT_TWO;

  alpr_ram #(
    .WIDTH (alpr_pkg::WORD_W),
    .DEPTH (alpr_pkg::DEPTH)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      alpr_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_push || empty) begin
            state_d = alpr_pkg::ST_DONE;
          end else begin
            state_d = alpr_pkg::ST_SCAN;
          end
        end
      end
      alpr_pkg::ST_SCAN: begin
        if (match) begin
          // later entries exist: the read of hit+1 is already in flight
          if (scan_next < fill_q) begin
            state_d = alpr_pkg::ST_SHIFT;
          end else begin
            state_d = alpr_pkg::ST_TAIL_RD;
          end
        end else if (scan_next == fill_q) begin
          state_d = alpr_pkg::ST_DONE;
        end
      end
      alpr_pkg::ST_SHIFT: begin
        // fill_q already holds the reduced count here
        if (ptr_next2 > fill_q) begin
          state_d = alpr_pkg::ST_TAIL_RD;
        end
      end
      alpr_pkg::ST_TAIL_RD: begin
        if (empty) begin
          state_d = alpr_pkg::ST_DONE;
        end else begin
          state_d = alpr_pkg::ST_TAIL_WAIT;
        end
      end
      alpr_pkg::ST_TAIL_WAIT: begin
        state_d = alpr_pkg::ST_DONE;
      end
      alpr_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = alpr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = alpr_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    fill_d      = fill_q;
    tail_d      = tail_q;
    value_d     = value_q;
    status_d    = status_q;
    pos_d       = pos_q;
    scan_d      = scan_q;
    ptr_d       = ptr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q;
    ram_wdata   = ram_rdata;
    ram_raddr   = '0;

    case (state_q)
      alpr_pkg::ST_IDLE: begin
        // read of entry 0 is issued every idle cycle for the scan
        if (accept) begin
          value_d  = in_data_i.value;
          status_d = alpr_pkg::STATUS_OK;
          pos_d    = '0;
          scan_d   = '0;
          if (is_push) begin
            if (full) begin
              status_d = alpr_pkg::STATUS_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = alpr_pkg::cnt_to_idx(fill_q);
              ram_wdata = in_data_i.value;
              pos_d     = alpr_pkg::cnt_to_idx(fill_q);
              fill_d    = fill_inc;
              tail_d    = in_data_i.value;
            end
          end else if (empty) begin
            status_d = alpr_pkg::STATUS_EMPTY;
          end
        end
      end
      alpr_pkg::ST_SCAN: begin
        ram_raddr = alpr_pkg::cnt_to_idx(scan_next);
        if (match) begin
          pos_d  = scan_q;
          ptr_d  = scan_q;
          fill_d = fill_dec;
        end else if (scan_next == fill_q) begin
          status_d = alpr_pkg::STATUS_NOT_FOUND;
        end else begin
          scan_d = alpr_pkg::cnt_to_idx(scan_next);
        end
      end
      alpr_pkg::ST_SHIFT: begin
        ram_raddr = alpr_pkg::cnt_to_idx(ptr_next2);
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = ram_rdata;
        ptr_d     = alpr_pkg::cnt_to_idx(ptr_inc);
      end
      alpr_pkg::ST_TAIL_RD: begin
        ram_raddr = alpr_pkg::cnt_to_idx(fill_dec);
        if (empty) begin
          tail_d = '0;
        end
      end
      alpr_pkg::ST_TAIL_WAIT: begin
        tail_d = ram_rdata;
      end
      alpr_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_data_d.status     = status_q;
          out_data_d.count      = alpr_pkg::cnt_to_count(fill_q);
          out_data_d.position   = alpr_pkg::idx_to_pos(pos_q);
          out_data_d.tail_value = tail_q;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= alpr_pkg::ST_IDLE;
      fill_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q    <= value_d;
    status_q   <= status_d;
    pos_q      <= pos_d;
    scan_q     <= scan_d;
    ptr_q      <= ptr_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ALPR_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= alpr_pkg::FULL_CNT, "fill count above depth")
  `ALPR_ASSERT_NEXT(a_push_grows, accept && is_push && !full, fill_q == $past(fill_inc), "push did not grow list")
  `ALPR_ASSERT_NEXT(a_done_holds, (state_q == alpr_pkg::ST_DONE) && !out_free, state_q == alpr_pkg::ST_DONE, "result dropped while output stalled")
  `ALPR_ASSERT_NOW(a_empty_count, out_valid_q && (out_data_q.status == alpr_pkg::STATUS_EMPTY), (out_data_q.count == '0) && (out_data_q.tail_value == '0), "empty result with nonzero count or tail")

endmodule

### tb/sv/array_list_push_remove_by_value_tb.sv
// Self-checking testbench for the push / remove-by-value word list.
`timescale 1ns / 1ps

module array_list_push_remove_by_value_tb;
  import alpr_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  // mirror of the list contents, index 0 is the head
  logic signed [WORD_W-1:0] held_words[$];
  out_beat_t                pending_results[$];
  int                       error_count = 0;
  bit                       calm_in = 1'b0;

  array_list_push_remove_by_value u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Applies one command to the mirrored list and returns the result it must give.
  function automatic out_beat_t update_list(input in_beat_t beat);
    out_beat_t res;
    int        hit;
    res = '0;
    res.status = STATUS_OK;
    hit = -1;
    if (beat.cmd == CMD_PUSH) begin
      if (held_words.size() >= DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        res.position = POS_W'(held_words.size());
        held_words.push_back(beat.value);
      end
    end else if (held_words.size() == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      foreach (held_words[i]) begin
        if (hit < 0 && held_words[i] == beat.value) hit = i;
      end
      if (hit < 0) begin
        res.status = STATUS_NOT_FOUND;
      end else begin
        held_words.delete(hit);
        res.position = POS_W'(hit);
      end
    end
    res.count = COUNT_W'(held_words.size());
    res.tail_value = (held_words.size() > 0) ? held_words[held_words.size() - 1] : '0;
    return res;
  endfunction

  // Mostly zero or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Mix of full-range words, a small pool for duplicates, and the extremes.
  function automatic logic signed [WORD_W-1:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom;
    if (r < 7) return $urandom_range(0, 7);
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh0000_0000;
        1:       return 32'shFFFF_FFFF;
        2:       return 32'sh7FFF_FFFF;
        default: return 32'sh8000_0000;
      endcase
    end
    return $signed($urandom_range(0, 15)) - 8;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    if (error_count <= 50)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Sends one command beat and records its expected result once accepted.
  task automatic send_cmd(input cmd_e cmd, input logic signed [WORD_W-1:0] value);
    in_beat_t beat;
    int       gap;
    beat.cmd = cmd;
    beat.value = value;
    gap = calm_in ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk_i); while (!in_ready);
    pending_results.push_back(update_list(beat));
  endtask

  task automatic remove_member();
    if (held_words.size() > 0)
      send_cmd(CMD_REMOVE, held_words[$urandom_range(0, held_words.size() - 1)]);
    else
      send_cmd(CMD_REMOVE, rand_word());
  endtask

  task automatic test_remove_when_empty();
    send_cmd(CMD_REMOVE, 32'sh0000_0000);
  endtask

  task automatic test_push_until_full();
    logic signed [WORD_W-1:0] fixed_words[8];
    fixed_words = '{32'sh0000_0000, 32'shFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                    32'sh0000_0005, 32'sh0000_0005, 32'sh5555_5555, 32'shAAAA_AAAA};
    for (int i = 0; i < DEPTH; i++)
      send_cmd(CMD_PUSH, (i < 8) ? fixed_words[i] : $urandom);
    send_cmd(CMD_PUSH, 32'sh1357_9BDF);
  endtask

  task automatic test_remove_cases();
    send_cmd(CMD_REMOVE, 32'sh1234_5678);                        // most likely absent
    send_cmd(CMD_REMOVE, 32'sh0000_0005);                        // first of a duplicate pair
    send_cmd(CMD_REMOVE, held_words[held_words.size() - 1]);     // tail
    send_cmd(CMD_REMOVE, held_words[0]);                         // head
    send_cmd(CMD_REMOVE, 32'sh8000_0000);
  endtask

  // Swings up to full and back down to empty, hitting both limits each round.
  task automatic test_fill_and_drain(input int rounds);
    for (int r = 0; r < rounds; r++) begin
      calm_in = r[0];
      while (held_words.size() < DEPTH) send_cmd(CMD_PUSH, rand_word());
      send_cmd(CMD_PUSH, rand_word());
      while (held_words.size() > 0) remove_member();
      send_cmd(CMD_REMOVE, rand_word());
    end
    calm_in = 1'b0;
  endtask

  task automatic test_random_mix(input int n_items);
    int push_pct;
    push_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 25;
          1:       push_pct = 50;
          default: push_pct = 75;
        endcase
        calm_in = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) < push_pct)
        send_cmd(CMD_PUSH, rand_word());
      else if ($urandom_range(0, 3) != 0)
        remove_member();
      else
        send_cmd(CMD_REMOVE, rand_word());
    end
    calm_in = 1'b0;
  endtask

  // result side back-pressure
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 4) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(50, 200)) @(posedge clk_i);
      end else begin
        stall = idle_len();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni === 1'b1 && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with none expected", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.count !== want.count)
          report_mismatch("count", out_data.count, want.count);
        if (out_data.position !== want.position)
          report_mismatch("position", out_data.position, want.position);
        if (out_data.tail_value !== want.tail_value)
          report_mismatch("tail_value", out_data.tail_value, want.tail_value);
      end
    end
  end

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_remove_when_empty();
    test_push_until_full();
    test_remove_cases();
    test_fill_and_drain(8);
    test_random_mix(1450);

    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (40) @(posedge clk_i);
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #12_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/alpr_pkg.sv
hdl/alpr_ram.sv
hdl/array_list_push_remove_by_value.sv
tb/sv/array_list_push_remove_by_value_tb.sv
